// ===== hw/rtl/bds_pkg.sv =====
package bds_pkg;

  localparam int PIX_W    = 8;
  localparam int LANE_W   = 14;
  localparam int LANES    = 4;
  localparam int SUM_W    = LANE_W * LANES;
  localparam int FACTOR_W = 4;
  localparam int SIZE_W   = 14;
  localparam int POS_W    = 13;
  localparam int OUT_X_W  = 10;
  localparam int OUT_Y_W  = 13;
  localparam int RECIP_W  = 23;
  localparam int RECIP_SH = 22;
  localparam int PROD_W   = LANE_W + RECIP_W;

  localparam logic [SIZE_W-1:0] MAX_SIZE = 14'd8192;

  localparam logic [1:0] REG_FACTOR    = 2'd0;
  localparam logic [1:0] REG_IN_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IN_HEIGHT = 2'd2;

  typedef logic [SUM_W-1:0] sum_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WB,
    S_DIV
  } bds_state_t;

  function automatic sum_t lane_add(input sum_t a, input sum_t b);
    sum_t r;
    r = '0;
    for (int k = 0; k < LANES; k++) begin
      r[k*LANE_W +: LANE_W] = a[k*LANE_W +: LANE_W] + b[k*LANE_W +: LANE_W];
    end
    return r;
  endfunction

  // Rounded-up reciprocals of factor squared, scaled by two to the power RECIP_SH.
  // They give exact truncating quotients for every 14-bit lane sum.
  function automatic logic [RECIP_W-1:0] recip(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      4'd0:    r = 23'd4194304;
      4'd1:    r = 23'd4194304;
      4'd2:    r = 23'd1048576;
      4'd3:    r = 23'd466034;
      4'd4:    r = 23'd262144;
      4'd5:    r = 23'd167773;
      4'd6:    r = 23'd116509;
      4'd7:    r = 23'd85599;
      4'd8:    r = 23'd65536;
      4'd9:    r = 23'd51782;
      4'd10:   r = 23'd41944;
      4'd11:   r = 23'd34664;
      4'd12:   r = 23'd29128;
      4'd13:   r = 23'd24819;
      4'd14:   r = 23'd21400;
      4'd15:   r = 23'd18642;
      default: r = 23'd4194304;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/bds_div.sv =====
module bds_div (
  input  logic [55:0] acc,
  input  logic [3:0]  factor,
  output logic [31:0] avg
);
  import bds_pkg::*;

  logic [RECIP_W-1:0] rcp;
  logic [PROD_W-1:0]  prod [LANES];

  assign rcp = recip(factor);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      prod[k] = PROD_W'(acc[k*LANE_W +: LANE_W]) * PROD_W'(rcp);
      avg[k*PIX_W +: PIX_W] = prod[k][RECIP_SH +: PIX_W];
    end
  end

endmodule

// ===== hw/rtl/box_downsample_rgba.sv =====
// Box-filter downsampler for RGBA. Supersampled pixels enter in raster order, one word per
// pixel, and each factor-by-factor block yields one averaged pixel with its output column
// and row. A pixel that closes a block row holds off the next word while the partial sum of
// its block goes through a read-modify-write of the single-port line store. A pixel that
// closes a whole block holds it off also through the reciprocal divide and until the output
// register can drain. Other pixels go through without a stall. The line store needs no
// clearing pass. Any register write restarts the frame at the top left corner.
module box_downsample_rgba #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_FACTOR    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16], alpha_in [31:24]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red_out [7:0], green_out [15:8], blue_out [23:16], alpha_out [31:24],
  // out_x [41:32], out_y [54:42], zero [55]
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bds_pkg::*;

  localparam int AW    = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int SUB_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

  logic [FACTOR_W-1:0] cfg_factor_r;
  logic [SIZE_W-1:0]   cfg_width_r, cfg_height_r;
  logic                cfg_wr;
  logic                cfg_restart;

  logic [FACTOR_W-1:0] f_eff, fm1;
  logic [SIZE_W-1:0]   w_eff, h_eff;

  bds_state_t state_r, state_nxt;

  logic [POS_W-1:0] in_col_r, in_col_nxt, in_row_r, in_row_nxt;
  logic [POS_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [SUB_W-1:0] sub_col_r, sub_col_nxt, sub_row_r, sub_row_nxt;
  sum_t             run_r, run_nxt;

  sum_t             px, blk_sum;
  logic             accept, col_last, row_last, row_end, frame_end, in_range;

  sum_t             blk_sum_r, rd_data_r, acc, acc_r;
  logic [POS_W-1:0] ox_hold_r, oy_hold_r;
  logic             first_row_r, last_row_r;
  logic             mem_re, mem_we, load_out;

  sum_t             line_mem [MAX_OUT_WIDTH];

  logic [31:0]      avg;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [55:0]      out_data_r;

  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_restart = cfg_wr
                    && (cfg_paddr[3:2] inside {REG_FACTOR, REG_IN_WIDTH, REG_IN_HEIGHT});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_factor_r <= 4'd2;
      cfg_width_r  <= 14'd2048;
      cfg_height_r <= 14'd2048;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FACTOR:    cfg_factor_r <= cfg_pwdata[FACTOR_W-1:0];
        REG_IN_WIDTH:  cfg_width_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_IN_HEIGHT: cfg_height_r <= cfg_pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FACTOR:    cfg_prdata = 32'(cfg_factor_r);
      REG_IN_WIDTH:  cfg_prdata = 32'(cfg_width_r);
      REG_IN_HEIGHT: cfg_prdata = 32'(cfg_height_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg_factor_r == '0) begin
      f_eff = 4'd1;
    end else if (5'(cfg_factor_r) > 5'(MAX_FACTOR)) begin
      f_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_eff = cfg_factor_r;
    end
    if (cfg_width_r == '0) begin
      w_eff = 14'd1;
    end else if (cfg_width_r > MAX_SIZE) begin
      w_eff = MAX_SIZE;
    end else begin
      w_eff = cfg_width_r;
    end
    if (cfg_height_r == '0) begin
      h_eff = 14'd1;
    end else if (cfg_height_r > MAX_SIZE) begin
      h_eff = MAX_SIZE;
    end else begin
      h_eff = cfg_height_r;
    end
    fm1 = f_eff - 4'd1;
  end

  // A block counts only when it lies wholly inside the image and the line store.
  always_comb begin
    px = '0;
    for (int k = 0; k < LANES; k++) begin
      px[k*LANE_W +: LANE_W] = LANE_W'(in_tdata[k*PIX_W +: PIX_W]);
    end
    accept    = in_tvalid && in_tready;
    col_last  = 5'(sub_col_r) == 5'(fm1);
    row_last  = 5'(sub_row_r) == 5'(fm1);
    row_end   = (SIZE_W'(in_col_r) + 14'd1) >= w_eff;
    frame_end = (SIZE_W'(in_row_r) + 14'd1) >= h_eff;
    in_range  = ((SIZE_W'(in_col_r) - SIZE_W'(sub_col_r) + SIZE_W'(f_eff)) <= w_eff)
             && ((SIZE_W'(in_row_r) - SIZE_W'(sub_row_r) + SIZE_W'(f_eff)) <= h_eff)
             && (SIZE_W'(ox_r) < SIZE_W'(MAX_OUT_WIDTH));
    blk_sum   = (sub_col_r == '0) ? px : lane_add(run_r, px);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    sub_col_nxt = sub_col_r;
    sub_row_nxt = sub_row_r;
    run_nxt     = run_r;
    if (cfg_restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      ox_nxt      = '0;
      oy_nxt      = '0;
      sub_col_nxt = '0;
      sub_row_nxt = '0;
      run_nxt     = '0;
    end else if (accept) begin
      if (in_range) begin
        run_nxt = col_last ? '0 : blk_sum;
      end
      if (row_end) begin
        in_col_nxt  = '0;
        sub_col_nxt = '0;
        ox_nxt      = '0;
        run_nxt     = '0;
        if (frame_end) begin
          in_row_nxt  = '0;
          sub_row_nxt = '0;
          oy_nxt      = '0;
        end else begin
          in_row_nxt  = in_row_r + 1'b1;
          sub_row_nxt = row_last ? '0 : sub_row_r + 1'b1;
          oy_nxt      = row_last ? oy_r + 1'b1 : oy_r;
        end
      end else begin
        in_col_nxt  = in_col_r + 1'b1;
        sub_col_nxt = col_last ? '0 : sub_col_r + 1'b1;
        ox_nxt      = col_last ? ox_r + 1'b1 : ox_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      ox_r      <= '0;
      oy_r      <= '0;
      sub_col_r <= '0;
      sub_row_r <= '0;
      run_r     <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      ox_r      <= ox_nxt;
      oy_r      <= oy_nxt;
      sub_col_r <= sub_col_nxt;
      sub_row_r <= sub_row_nxt;
      run_r     <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_sum_r   <= blk_sum;
      ox_hold_r   <= ox_r;
      oy_hold_r   <= oy_r;
      first_row_r <= sub_row_r == '0;
      last_row_r  <= row_last;
    end
    if (state_r == S_WB) begin
      acc_r <= acc;
    end
  end

  assign acc = first_row_r ? blk_sum_r : lane_add(rd_data_r, blk_sum_r);

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_range && col_last) begin
          mem_re    = 1'b1;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        mem_we    = 1'b1;
        state_nxt = last_row_r ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[ox_hold_r[AW-1:0]] <= acc;
    end
    if (mem_re) begin
      rd_data_r <= line_mem[ox_r[AW-1:0]];
    end
  end

  bds_div u_div (
    .acc    (acc_r),
    .factor (f_eff),
    .avg    (avg)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {1'b0, oy_hold_r[OUT_Y_W-1:0], ox_hold_r[OUT_X_W-1:0], avg};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("line store read and write in the same cycle");

  a_wb_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |-> $past(in_tvalid && in_tready))
    else $error("write-back without an accepted word");

  a_div_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && $past(state_r == S_WB)) |-> $past(last_row_r))
    else $error("divide entered for a block that is not complete");

  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DIV))
    else $error("output word raised outside the divide step");

  a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (5'(sub_col_r) < 5'(f_eff)) && (5'(sub_row_r) < 5'(f_eff)))
    else $error("position inside block exceeds the factor");
`endif

endmodule
